// ----- sv/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Shared widths, codes, the line setup record and small coordinate helpers.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS = 10;
    localparam int CFG_W      = 11;
    localparam int COLOR_W    = 16;
    localparam int ERR_W      = COORD_BITS + 1;
    localparam int CNT_W      = COORD_BITS + 1;
    localparam int CMP_W      = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [0:0] {
        KIND_LINE = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd3
    } dir_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t col_delta;
        coord_t row_delta;
        coord_t major;
        dir_t   col_dir;
        dir_t   row_dir;
    } line_setup_t;

    function automatic coord_t clamp_coord(coord_t v, logic [CFG_W-1:0] size);
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] lim_m1;
        coord_t           c;
        lim    = (size == '0) ? CMP_W'(1) : CMP_W'(size);
        lim_m1 = lim - CMP_W'(1);
        c      = v;
        if (CMP_W'(v) >= lim) begin
            c = lim_m1[COORD_BITS-1:0];
        end
        return c;
    endfunction

    function automatic coord_t step_coord(coord_t c, dir_t dir);
        coord_t r;
        case (dir)
            DIR_INC: r = c + coord_t'(1);
            DIR_DEC: r = c - coord_t'(1);
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/lpr_setup.sv -----
// ----------------------------------------------------------------------------
// Line setup
// Clamps both endpoints to the display and derives deltas, step directions
// and the major-axis length of a new line.
// ----------------------------------------------------------------------------
module lpr_setup (
    input  lpr_pkg::coord_t             start_x,
    input  lpr_pkg::coord_t             start_y,
    input  lpr_pkg::coord_t             end_x,
    input  lpr_pkg::coord_t             end_y,
    input  logic [lpr_pkg::CFG_W-1:0]   display_width,
    input  logic [lpr_pkg::CFG_W-1:0]   display_height,
    output lpr_pkg::line_setup_t        setup
);

    lpr_pkg::coord_t x1, y1, x2, y2;

    always_comb begin
        x1 = lpr_pkg::clamp_coord(start_x, display_width);
        y1 = lpr_pkg::clamp_coord(start_y, display_height);
        x2 = lpr_pkg::clamp_coord(end_x, display_width);
        y2 = lpr_pkg::clamp_coord(end_y, display_height);

        setup.x1 = x1;
        setup.y1 = y1;

        if (x2 > x1) begin
            setup.col_delta = x2 - x1;
            setup.col_dir   = lpr_pkg::DIR_INC;
        end else if (x2 == x1) begin
            setup.col_delta = '0;
            setup.col_dir   = lpr_pkg::DIR_NONE;
        end else begin
            setup.col_delta = x1 - x2;
            setup.col_dir   = lpr_pkg::DIR_DEC;
        end

        if (y2 > y1) begin
            setup.row_delta = y2 - y1;
            setup.row_dir   = lpr_pkg::DIR_INC;
        end else if (y2 == y1) begin
            setup.row_delta = '0;
            setup.row_dir   = lpr_pkg::DIR_NONE;
        end else begin
            setup.row_delta = y1 - y2;
            setup.row_dir   = lpr_pkg::DIR_DEC;
        end

        setup.major = (setup.col_delta > setup.row_delta) ? setup.col_delta
                                                          : setup.row_delta;
    end

endmodule

// ----- sv/lpr_step.sv -----
// ----------------------------------------------------------------------------
// Line stepper
// Holds the line state, emits one pixel per tick with error accumulators
// on both axes, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module lpr_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          item_valid,
    input  lpr_pkg::kind_t                kind,
    input  lpr_pkg::line_setup_t          setup,
    input  logic [lpr_pkg::COLOR_W-1:0]   color,
    output logic                          out_valid,
    output lpr_pkg::coord_t               out_x,
    output lpr_pkg::coord_t               out_y,
    output logic [lpr_pkg::COLOR_W-1:0]   out_color,
    output logic                          out_last
);

    lpr_pkg::coord_t                 cur_col_reg, cur_col_next;
    lpr_pkg::coord_t                 cur_row_reg, cur_row_next;
    logic [lpr_pkg::ERR_W-1:0]       col_err_reg, col_err_next;
    logic [lpr_pkg::ERR_W-1:0]       row_err_reg, row_err_next;
    lpr_pkg::coord_t                 col_delta_reg, col_delta_next;
    lpr_pkg::coord_t                 row_delta_reg, row_delta_next;
    lpr_pkg::coord_t                 major_reg, major_next;
    lpr_pkg::dir_t                   col_dir_reg, col_dir_next;
    lpr_pkg::dir_t                   row_dir_reg, row_dir_next;
    logic [lpr_pkg::CNT_W-1:0]       left_reg, left_next;
    logic [lpr_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic                            busy_reg, busy_next;

    logic                            out_valid_reg, out_valid_next;
    lpr_pkg::coord_t                 out_x_reg, out_x_next;
    lpr_pkg::coord_t                 out_y_reg, out_y_next;
    logic [lpr_pkg::COLOR_W-1:0]     out_color_reg, out_color_next;
    logic                            out_last_reg, out_last_next;

    logic [lpr_pkg::ERR_W-1:0]       col_sum, row_sum, major_ext;

    always_comb begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        col_err_next   = col_err_reg;
        row_err_next   = row_err_reg;
        col_delta_next = col_delta_reg;
        row_delta_next = row_delta_reg;
        major_next     = major_reg;
        col_dir_next   = col_dir_reg;
        row_dir_next   = row_dir_reg;
        left_next      = left_reg;
        color_next     = color_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        major_ext = lpr_pkg::ERR_W'(major_reg);
        col_sum   = col_err_reg + lpr_pkg::ERR_W'(col_delta_reg);
        row_sum   = row_err_reg + lpr_pkg::ERR_W'(row_delta_reg);

        if (advance) begin
            out_valid_next = 1'b0;
            if (item_valid) begin
                if (kind == lpr_pkg::KIND_LINE) begin
                    cur_col_next   = setup.x1;
                    cur_row_next   = setup.y1;
                    col_err_next   = '0;
                    row_err_next   = '0;
                    col_delta_next = setup.col_delta;
                    row_delta_next = setup.row_delta;
                    major_next     = setup.major;
                    col_dir_next   = setup.col_dir;
                    row_dir_next   = setup.row_dir;
                    left_next      = lpr_pkg::CNT_W'(setup.major) + lpr_pkg::CNT_W'(2);
                    color_next     = color;
                    busy_next      = 1'b1;
                end else if (busy_reg) begin
                    out_valid_next = 1'b1;
                    out_x_next     = cur_col_reg;
                    out_y_next     = cur_row_reg;
                    out_color_next = color_reg;
                    out_last_next  = (left_reg == lpr_pkg::CNT_W'(1));

                    col_err_next = col_sum;
                    if (col_sum > major_ext) begin
                        col_err_next = col_sum - major_ext;
                        cur_col_next = lpr_pkg::step_coord(cur_col_reg, col_dir_reg);
                    end
                    row_err_next = row_sum;
                    if (row_sum > major_ext) begin
                        row_err_next = row_sum - major_ext;
                        cur_row_next = lpr_pkg::step_coord(cur_row_reg, row_dir_reg);
                    end

                    left_next = left_reg - lpr_pkg::CNT_W'(1);
                    if (left_reg == lpr_pkg::CNT_W'(1)) begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_col_reg   <= cur_col_next;
        cur_row_reg   <= cur_row_next;
        col_err_reg   <= col_err_next;
        row_err_reg   <= row_err_next;
        col_delta_reg <= col_delta_next;
        row_delta_reg <= row_delta_next;
        major_reg     <= major_next;
        col_dir_reg   <= col_dir_next;
        row_dir_reg   <= row_dir_next;
        color_reg     <= color_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;

    // A line only ends by handing out its marked final pixel.
    a_end_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> (out_valid_reg && out_last_reg))
        else $error("line ended without a last pixel");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (left_reg != '0))
        else $error("busy with no pixels left");

    a_col_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (col_err_reg <= lpr_pkg::ERR_W'(major_reg)))
        else $error("column error above major length");

    a_row_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (row_err_reg <= lpr_pkg::ERR_W'(major_reg)))
        else $error("row error above major length");

endmodule

// ----- sv/line_pixel_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Line pixel rasterizer
// Clamps line endpoints to the display and emits one pixel per tick.
// ----------------------------------------------------------------------------
// A tick passes through the input register and then the result register
// before its pixel is offered on m_tvalid.
// Throughput: one command or tick transfer per cycle unless the pixel output
// stalls, set by the single input and result registers around the step logic.
// Reset (aresetn low, synchronous) leaves the block idle with no pending
// transfer and sets the display size to 320 by 480.
module line_pixel_rasterizer (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [lpr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lpr_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, end_x, end_y, color
    input  logic [lpr_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [lpr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    localparam int CB = lpr_pkg::COORD_BITS;
    localparam int CW = lpr_pkg::COLOR_W;

    logic [lpr_pkg::CFG_W-1:0]       width_reg, width_next;
    logic [lpr_pkg::CFG_W-1:0]       height_reg, height_next;

    logic                            in_valid_reg, in_valid_next;
    logic                            in_kind_reg, in_kind_next;
    logic [lpr_pkg::S_TDATA_W-1:0]   in_data_reg, in_data_next;

    logic                            advance;
    lpr_pkg::line_setup_t            setup;
    lpr_pkg::coord_t                 px, py;
    logic [CW-1:0]                   pcolor;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (lpr_pkg::cfg_reg_t'(cfg_addr))
                lpr_pkg::REG_WIDTH:  width_next  = cfg_wdata;
                lpr_pkg::REG_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_kind_next  = in_kind_reg;
        in_data_next  = in_data_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_kind_next  = s_tuser;
            in_data_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= lpr_pkg::WIDTH_RESET;
            height_reg   <= lpr_pkg::HEIGHT_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_kind_reg <= in_kind_next;
        in_data_reg <= in_data_next;
    end

    lpr_setup u_setup (
        .start_x        (in_data_reg[CB-1:0]),
        .start_y        (in_data_reg[2*CB-1:CB]),
        .end_x          (in_data_reg[3*CB-1:2*CB]),
        .end_y          (in_data_reg[4*CB-1:3*CB]),
        .display_width  (width_reg),
        .display_height (height_reg),
        .setup          (setup)
    );

    lpr_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item_valid (in_valid_reg),
        .kind       (lpr_pkg::kind_t'(in_kind_reg)),
        .setup      (setup),
        .color      (in_data_reg[4*CB+CW-1:4*CB]),
        .out_valid  (m_tvalid),
        .out_x      (px),
        .out_y      (py),
        .out_color  (pcolor),
        .out_last   (m_tlast)
    );

    assign m_tdata = lpr_pkg::M_TDATA_W'({pcolor, py, px});

endmodule
